// ===== sv/source_byte_tokenizer_defines.svh =====
// ----------------------------------------------------------------------------
// Source byte tokenizer assertion macros
// Shared concurrent assertion wrappers for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef SOURCE_BYTE_TOKENIZER_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SBT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Source byte tokenizer package
// Token, error and mode codes, result type and keyword lookup.
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int unsigned OffsetBitsDef   = 32;
  localparam int unsigned LengthBitsDef   = 16;
  localparam int unsigned LineBitsDef     = 24;
  localparam int unsigned KeywordCharsDef = 8;

  localparam int unsigned KindBits = 6;
  localparam int unsigned ErrBits  = 2;

  localparam logic [KindBits-1:0] KindEnd     = 6'd0;
  localparam logic [KindBits-1:0] KindIdent   = 6'd1;
  localparam logic [KindBits-1:0] KindNumber  = 6'd2;
  localparam logic [KindBits-1:0] KindString  = 6'd3;
  localparam logic [KindBits-1:0] KindInvalid = 6'd4;
  localparam logic [KindBits-1:0] KindKwBase  = 6'd5;
  localparam logic [KindBits-1:0] KindNone    = 6'd0;

  localparam logic [ErrBits-1:0] ErrNone    = 2'd0;
  localparam logic [ErrBits-1:0] ErrBadChar = 2'd1;
  localparam logic [ErrBits-1:0] ErrUnterm  = 2'd2;

  // Pending operator codes.
  localparam logic [2:0] PendEq    = 3'd0;
  localparam logic [2:0] PendBang  = 3'd1;
  localparam logic [2:0] PendLt    = 3'd2;
  localparam logic [2:0] PendGt    = 3'd3;
  localparam logic [2:0] PendAmp   = 3'd4;
  localparam logic [2:0] PendBar   = 3'd5;
  localparam logic [2:0] PendSlash = 3'd6;

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeOp      = 3'd1,
    ModeNumber  = 3'd2,
    ModeIdent   = 3'd3,
    ModeString  = 3'd4,
    ModeComment = 3'd5
  } mode_e;

  // One token as produced by the scanner, with a 64-bit offset and a 32-bit length.
  typedef struct packed {
    logic [KindBits-1:0] kind;
    logic [ErrBits-1:0]  err;
    logic [63:0]         start;
    logic [31:0]         len;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == 8'h5f);
  endfunction

  function automatic logic [KindBits-1:0] single_kind(input logic [7:0] c);
    logic [KindBits-1:0] k;
    case (c)
      8'h2b:   k = 6'd23;
      8'h2d:   k = 6'd24;
      8'h2a:   k = 6'd25;
      8'h25:   k = 6'd27;
      8'h3b:   k = 6'd38;
      8'h2c:   k = 6'd39;
      8'h2e:   k = 6'd40;
      8'h28:   k = 6'd41;
      8'h29:   k = 6'd42;
      8'h7b:   k = 6'd43;
      8'h7d:   k = 6'd44;
      8'h5b:   k = 6'd45;
      8'h5d:   k = 6'd46;
      default: k = KindNone;
    endcase
    return k;
  endfunction

  function automatic logic [KindBits-1:0] op_single(input logic [2:0] p);
    logic [KindBits-1:0] k;
    case (p)
      PendEq:    k = 6'd28;
      PendBang:  k = 6'd30;
      PendLt:    k = 6'd32;
      PendGt:    k = 6'd34;
      PendSlash: k = 6'd26;
      default:   k = KindNone;
    endcase
    return k;
  endfunction

  function automatic logic [KindBits-1:0] op_double(input logic [2:0] p);
    logic [KindBits-1:0] k;
    case (p)
      PendEq:   k = 6'd29;
      PendBang: k = 6'd31;
      PendLt:   k = 6'd33;
      PendGt:   k = 6'd35;
      PendAmp:  k = 6'd36;
      PendBar:  k = 6'd37;
      default:  k = KindNone;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      PendAmp:   c = 8'h26;
      PendBar:   c = 8'h7c;
      PendSlash: c = 8'h2f;
      default:   c = 8'h3d;
    endcase
    return c;
  endfunction

  // Returns 0..6 with hit set for a two-character-capable operator start, else hit clear.
  function automatic logic [2:0] op_first_code(input logic [7:0] c, output logic hit);
    logic [2:0] p;
    hit = 1'b1;
    case (c)
      8'h3d:   p = PendEq;
      8'h21:   p = PendBang;
      8'h3c:   p = PendLt;
      8'h3e:   p = PendGt;
      8'h26:   p = PendAmp;
      8'h7c:   p = PendBar;
      8'h2f:   p = PendSlash;
      default: begin
        p = PendEq;
        hit = 1'b0;
      end
    endcase
    return p;
  endfunction

  // Keyword match on the first eight buffered characters; byte 0 lowest.
  function automatic logic [KindBits-1:0] keyword_kind(input logic [63:0] w,
                                                       input logic [3:0] n);
    logic [KindBits-1:0] k;
    k = KindIdent;
    case ({n, w})
      {4'd3, 64'h0000_0000_0074_656c}: k = 6'd5;
      {4'd8, 64'h6e6f_6974_636e_7566}: k = 6'd6;
      {4'd2, 64'h0000_0000_0000_6669}: k = 6'd7;
      {4'd4, 64'h0000_0000_6573_6c65}: k = 6'd8;
      {4'd5, 64'h0000_0065_6c69_6877}: k = 6'd9;
      {4'd3, 64'h0000_0000_0072_6f66}: k = 6'd10;
      {4'd6, 64'h0000_6e72_7574_6572}: k = 6'd11;
      {4'd6, 64'h0000_6863_7469_7773}: k = 6'd12;
      {4'd4, 64'h0000_0000_6573_6163}: k = 6'd13;
      {4'd7, 64'h0074_6c75_6166_6564}: k = 6'd14;
      {4'd5, 64'h0000_006b_6165_7262}: k = 6'd15;
      {4'd8, 64'h6575_6e69_746e_6f63}: k = 6'd16;
      {4'd4, 64'h0000_0000_6575_7274}: k = 6'd17;
      {4'd5, 64'h0000_0065_736c_6166}: k = 6'd18;
      {4'd5, 64'h0000_0073_7361_6c63}: k = 6'd19;
      {4'd6, 64'h0000_7463_7572_7473}: k = 6'd20;
      {4'd5, 64'h0000_0074_6e69_7270}: k = 6'd21;
      {4'd5, 64'h0000_0074_7570_6e69}: k = 6'd22;
      default: k = KindIdent;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/source_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Source byte tokenizer
// Streams source bytes in and token descriptors out.
// ----------------------------------------------------------------------------
//  channel | direction | tdata fields (low bit up)                   | tuser
//  s_axis  | in        | source_byte[7:0]                            | final_byte
//  m_axis  | out       | kind, error, offset, length, line           | run_end
//
// A byte is scanned in the cycle it is accepted; its tokens are loaded into
// a three-entry output buffer. One byte per cycle is taken while that byte
// gives at most one token and the buffer drains; a byte that gives two or
// three tokens holds the input while they leave.
// Reset puts the scanner in idle at offset 0, line 1.
// ----------------------------------------------------------------------------
module source_byte_tokenizer #(
  parameter int unsigned OffsetBits   = sbt_pkg::OffsetBitsDef,
  parameter int unsigned LengthBits   = sbt_pkg::LengthBitsDef,
  parameter int unsigned LineBits     = sbt_pkg::LineBitsDef,
  parameter int unsigned KeywordChars = sbt_pkg::KeywordCharsDef,
  localparam int unsigned DataBits = 6 + 2 + OffsetBits + LengthBits + LineBits,
  localparam int unsigned DataBytes = (DataBits + 7) / 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // source_byte
  input  logic                   s_axis_tuser,  // final_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // token_kind, error_kind, start_offset, token_length, line_number, zero fill
  output logic [DataBytes*8-1:0] m_axis_tdata,
  output logic                   m_axis_tuser   // run_end
);

  typedef struct packed {
    logic [LineBits-1:0]   line;
    logic [LengthBits-1:0] len;
    logic [OffsetBits-1:0] start;
    logic [1:0]            err;
    logic [5:0]            kind;
  } out_t;

  logic                  step;
  logic [1:0]            cnt;
  sbt_pkg::token_t [2:0] tok;
  logic [LineBits-1:0]   line_a, line_b;
  out_t                  buf_q [3];
  logic [1:0]            fill_q, head_q;
  logic [2:0]            last_q;
  logic                  pop;

  localparam logic [31:0] LenMax = 32'((64'd1 << LengthBits) - 1);

  sbt_scanner #(
    .OffsetBits(OffsetBits), .LengthBits(LengthBits),
    .LineBits(LineBits), .KeywordChars(KeywordChars)
  ) u_scan (
    .clk_i, .rst_ni, .step_i(step), .byte_i(s_axis_tdata), .final_i(s_axis_tuser),
    .count_o(cnt), .tok_o(tok), .line_a_o(line_a), .line_b_o(line_b)
  );

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (fill_q == 2'd0) || (fill_q == 2'd1 && pop);
  assign step          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = fill_q != 2'd0;
  assign m_axis_tdata  = (DataBytes*8)'(buf_q[head_q]);
  assign m_axis_tuser  = last_q[head_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      head_q <= '0;
      last_q <= '0;
    end else if (step) begin
      fill_q <= cnt;
      head_q <= '0;
      for (int i = 0; i < 3; i++) last_q[i] <= (2'(i + 1) == cnt);
    end else if (pop) begin
      fill_q <= fill_q - 2'd1;
      head_q <= head_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      for (int i = 0; i < 3; i++) begin
        buf_q[i].kind  <= tok[i].kind;
        buf_q[i].err   <= tok[i].err;
        buf_q[i].start <= tok[i].start[OffsetBits-1:0];
        buf_q[i].len   <= (tok[i].len > LenMax) ? LengthBits'(LenMax)
                                                : tok[i].len[LengthBits-1:0];
        buf_q[i].line  <= (i == 0) ? line_a : line_b;
      end
    end
  end

endmodule

// ===== sv/sbt_scanner.sv =====
// ----------------------------------------------------------------------------
// Tokenizer scanner core
// Holds the scan state and, for each byte, produces up to three tokens.
// ----------------------------------------------------------------------------
`include "source_byte_tokenizer_defines.svh"

module sbt_scanner #(
  parameter int unsigned OffsetBits   = sbt_pkg::OffsetBitsDef,
  parameter int unsigned LengthBits   = sbt_pkg::LengthBitsDef,
  parameter int unsigned LineBits     = sbt_pkg::LineBitsDef,
  parameter int unsigned KeywordChars = sbt_pkg::KeywordCharsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  final_i,
  output logic [1:0]            count_o,
  output sbt_pkg::token_t [2:0] tok_o,
  output logic [LineBits-1:0]   line_a_o,
  output logic [LineBits-1:0]   line_b_o
);

  localparam int unsigned IdxBits = $clog2(KeywordChars);

  sbt_pkg::mode_e          mode_q, mode_d;
  logic [2:0]              pend_q, pend_d;
  logic [7:0]              word_q [KeywordChars];
  logic [7:0]              word_d [KeywordChars];
  logic [LengthBits-1:0]   len_q, len_d;
  logic [OffsetBits-1:0]   start_q, start_d;
  logic [OffsetBits-1:0]   pos_q, pos_d;
  logic [LineBits-1:0]     line_q, line_d, line_mid;
  logic                    first_tok;

  localparam logic [LengthBits-1:0] LenMax  = {LengthBits{1'b1}};
  localparam logic [LineBits-1:0]   LineMax = {LineBits{1'b1}};

  always_comb begin
    sbt_pkg::token_t t;
    logic [1:0]      n;
    logic            restart;
    logic            hit;
    logic [2:0]      pc;
    logic [2:0]      p;
    logic [63:0]     w;
    logic [3:0]      wl;
    logic [LengthBits-1:0] ulen;

    mode_d  = mode_q;
    pend_d  = pend_q;
    word_d  = word_q;
    len_d   = len_q;
    start_d = start_q;
    line_d  = line_q;
    pos_d   = pos_q + 1'b1;
    tok_o   = '0;
    n       = 2'd0;
    restart = 1'b0;
    hit     = 1'b0;
    pc      = '0;
    ulen    = '0;
    p       = (pend_q < 3'd7) ? pend_q : sbt_pkg::PendEq;
    t       = '0;
    w       = '0;
    for (int i = 0; i < 8; i++) w[i*8 +: 8] = word_q[i];
    wl      = (len_q <= LengthBits'(8)) ? 4'(len_q) : 4'd0;

    unique case (mode_q)
      sbt_pkg::ModeOp: begin
        if (byte_i == sbt_pkg::op_second(p)) begin
          if (p == sbt_pkg::PendSlash) begin
            mode_d = sbt_pkg::ModeComment;
          end else begin
            t = '{sbt_pkg::op_double(p), sbt_pkg::ErrNone, 64'(start_q), 32'd2};
            tok_o[n] = t;
            n = n + 2'd1;
            mode_d = sbt_pkg::ModeIdle;
          end
        end else begin
          if (sbt_pkg::op_single(pend_q) != sbt_pkg::KindNone) begin
            t = '{sbt_pkg::op_single(pend_q), sbt_pkg::ErrNone, 64'(start_q), 32'd1};
            tok_o[n] = t;
            n = n + 2'd1;
          end
          restart = 1'b1;
        end
      end
      sbt_pkg::ModeNumber: begin
        if (sbt_pkg::is_digit(byte_i)) begin
          if (len_q != LenMax) len_d = len_q + 1'b1;
        end else begin
          t = '{sbt_pkg::KindNumber, sbt_pkg::ErrNone, 64'(start_q), 32'(len_q)};
          tok_o[n] = t;
          n = n + 2'd1;
          restart = 1'b1;
        end
      end
      sbt_pkg::ModeIdent: begin
        if (sbt_pkg::is_alpha(byte_i) || sbt_pkg::is_digit(byte_i)) begin
          if (len_q < LengthBits'(KeywordChars)) word_d[len_q[IdxBits-1:0]] = byte_i;
          if (len_q != LenMax) len_d = len_q + 1'b1;
        end else begin
          t = '{sbt_pkg::keyword_kind(w, wl), sbt_pkg::ErrNone, 64'(start_q),
                32'(len_q)};
          tok_o[n] = t;
          n = n + 2'd1;
          restart = 1'b1;
        end
      end
      sbt_pkg::ModeString: begin
        if (byte_i == 8'h22) begin
          t = '{sbt_pkg::KindString, sbt_pkg::ErrNone, 64'(start_q + 1'b1),
                32'(len_q)};
          tok_o[n] = t;
          n = n + 2'd1;
          mode_d = sbt_pkg::ModeIdle;
        end else begin
          if (byte_i == 8'h0a && line_q != LineMax) line_d = line_q + 1'b1;
          if (len_q != LenMax) len_d = len_q + 1'b1;
        end
      end
      sbt_pkg::ModeComment: begin
        if (byte_i == 8'h0a) restart = 1'b1;
      end
      default: restart = 1'b1;
    endcase

    if (restart) begin
      mode_d = sbt_pkg::ModeIdle;
      pc = sbt_pkg::op_first_code(byte_i, hit);
      if (sbt_pkg::single_kind(byte_i) != sbt_pkg::KindNone) begin
        t = '{sbt_pkg::single_kind(byte_i), sbt_pkg::ErrNone, 64'(pos_q), 32'd1};
        tok_o[n] = t;
        n = n + 2'd1;
      end else if (hit) begin
        mode_d  = sbt_pkg::ModeOp;
        pend_d  = pc;
        start_d = pos_q;
      end else if (byte_i == 8'h20 || byte_i == 8'h09 || byte_i == 8'h0d) begin
        mode_d = sbt_pkg::ModeIdle;
      end else if (byte_i == 8'h0a) begin
        if (line_q != LineMax) line_d = line_q + 1'b1;
      end else if (byte_i == 8'h22) begin
        mode_d  = sbt_pkg::ModeString;
        start_d = pos_q;
        len_d   = '0;
      end else if (sbt_pkg::is_digit(byte_i)) begin
        mode_d  = sbt_pkg::ModeNumber;
        start_d = pos_q;
        len_d   = LengthBits'(1);
      end else if (sbt_pkg::is_alpha(byte_i)) begin
        mode_d  = sbt_pkg::ModeIdent;
        start_d = pos_q;
        len_d   = LengthBits'(1);
        for (int i = 0; i < KeywordChars; i++) word_d[i] = 8'h00;
        word_d[0] = byte_i;
      end else begin
        t = '{sbt_pkg::KindInvalid, sbt_pkg::ErrBadChar, 64'(pos_q), 32'd1};
        tok_o[n] = t;
        n = n + 2'd1;
      end
    end

    // Tokens emitted so far were closed before any newline of this byte was
    // counted; the flush and end tokens below see the updated line.
    first_tok = (n != 2'd0);
    line_mid  = line_d;

    if (final_i) begin
      for (int i = 0; i < 8; i++) w[i*8 +: 8] = word_d[i];
      wl = (len_d <= LengthBits'(8)) ? 4'(len_d) : 4'd0;
      ulen = (len_d != LenMax) ? len_d + 1'b1 : LenMax;
      case (mode_d)
        sbt_pkg::ModeOp: begin
          if (sbt_pkg::op_single(pend_d) != sbt_pkg::KindNone) begin
            t = '{sbt_pkg::op_single(pend_d), sbt_pkg::ErrNone, 64'(start_d), 32'd1};
            tok_o[n] = t;
            n = n + 2'd1;
          end
        end
        sbt_pkg::ModeNumber: begin
          t = '{sbt_pkg::KindNumber, sbt_pkg::ErrNone, 64'(start_d), 32'(len_d)};
          tok_o[n] = t;
          n = n + 2'd1;
        end
        sbt_pkg::ModeIdent: begin
          t = '{sbt_pkg::keyword_kind(w, wl), sbt_pkg::ErrNone, 64'(start_d),
                32'(len_d)};
          tok_o[n] = t;
          n = n + 2'd1;
        end
        sbt_pkg::ModeString: begin
          t = '{sbt_pkg::KindInvalid, sbt_pkg::ErrUnterm, 64'(start_d), 32'(ulen)};
          tok_o[n] = t;
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      t = '{sbt_pkg::KindEnd, sbt_pkg::ErrNone, 64'(pos_d), 32'd0};
      tok_o[n] = t;
      n = n + 2'd1;
      mode_d  = sbt_pkg::ModeIdle;
      pend_d  = '0;
      for (int i = 0; i < KeywordChars; i++) word_d[i] = 8'h00;
      len_d   = '0;
      start_d = '0;
      pos_d   = '0;
      line_d  = LineBits'(1);
    end
    count_o = n;
  end

  // A byte that changes the line closes at most one token before it, so only
  // the first slot can need the old line.
  assign line_a_o = first_tok ? line_q : line_mid;
  assign line_b_o = line_mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sbt_pkg::ModeIdle;
      pend_q  <= '0;
      len_q   <= '0;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= LineBits'(1);
      for (int i = 0; i < KeywordChars; i++) word_q[i] <= 8'h00;
    end else if (step_i) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      len_q   <= len_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      word_q  <= word_d;
    end
  end

  `SBT_ASSERT_IMP(a_line_nonzero, clk_i, rst_ni, 1'b1, line_q != '0, "line count is zero")
  `SBT_ASSERT_IMP(a_final_emits, clk_i, rst_ni, step_i && final_i, count_o != 2'd0,
                  "final byte gives no end token")
  `SBT_ASSERT_NEXT(a_final_resets, clk_i, rst_ni, step_i && final_i,
                   pos_q == '0 && mode_q == sbt_pkg::ModeIdle, "no reset after final byte")

endmodule

// ===== tb/sv/source_byte_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// Source byte tokenizer testbench
// Streams directed and random source texts into the tokenizer, predicts the
// token stream with a behavioral scanner and checks every output transaction
// field by field, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module source_byte_tokenizer_tb;

  localparam int unsigned WatchLimit = 2000;

  // Operator token kinds.
  localparam logic [5:0] KPlus = 6'd23, KMinus = 6'd24, KStar = 6'd25, KSlash = 6'd26;
  localparam logic [5:0] KPct = 6'd27, KAssign = 6'd28, KEq = 6'd29, KNot = 6'd30;
  localparam logic [5:0] KNe = 6'd31, KLt = 6'd32, KLe = 6'd33, KGt = 6'd34;
  localparam logic [5:0] KGe = 6'd35, KAnd = 6'd36, KOr = 6'd37, KSemi = 6'd38;
  localparam logic [5:0] KComma = 6'd39, KDot = 6'd40, KLpar = 6'd41, KRpar = 6'd42;
  localparam logic [5:0] KLbr = 6'd43, KRbr = 6'd44, KLsq = 6'd45, KRsq = 6'd46;

  typedef struct {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [31:0] start;
    logic [15:0] len;
    logic [23:0] line;
    logic        last;
  } token_rec_t;

  typedef struct {
    logic [7:0] c;
    logic       fin;
    logic       typed;
    logic [5:0] kind;
    logic [1:0] err;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;

  source_byte_tokenizer uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  token_rec_t token_q[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  logic [7:0] text_q[$];

  // Scanner shadow state.
  sbt_pkg::mode_e sh_mode;
  logic [2:0]  sh_pend;
  logic [7:0]  sh_word[8];
  logic [15:0] sh_len;
  logic [31:0] sh_start;
  logic [31:0] sh_pos;
  logic [23:0] sh_line;

  string keywords[18] = '{"let", "function", "if", "else", "while", "for", "return",
                          "switch", "case", "default", "break", "continue", "true",
                          "false", "class", "struct", "print", "input"};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic scanner_clear();
    sh_mode = sbt_pkg::ModeIdle;
    sh_pend = sbt_pkg::PendEq;
    foreach (sh_word[i]) sh_word[i] = 8'h00;
    sh_len = '0;
    sh_start = '0;
    sh_pos = '0;
    sh_line = 24'd1;
  endtask

  task automatic push_token(logic [5:0] kind, logic [1:0] err, logic [31:0] start,
                            logic [15:0] len);
    token_rec_t t;
    t.kind = kind;
    t.err = err;
    t.start = start;
    t.len = len;
    t.line = sh_line;
    t.last = 1'b0;
    token_q.push_back(t);
  endtask

  function automatic logic digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [5:0] lone_kind(logic [7:0] c);
    case (c)
      "+": return KPlus;
      "-": return KMinus;
      "*": return KStar;
      "%": return KPct;
      ";": return KSemi;
      ",": return KComma;
      ".": return KDot;
      "(": return KLpar;
      ")": return KRpar;
      "{": return KLbr;
      "}": return KRbr;
      "[": return KLsq;
      "]": return KRsq;
      default: return sbt_pkg::KindNone;
    endcase
  endfunction

  function automatic logic [7:0] pend_follow(logic [2:0] p);
    case (p)
      sbt_pkg::PendAmp: return "&";
      sbt_pkg::PendBar: return "|";
      sbt_pkg::PendSlash: return "/";
      default: return "=";
    endcase
  endfunction

  function automatic logic [5:0] pend_pair_kind(logic [2:0] p);
    case (p)
      sbt_pkg::PendEq: return KEq;
      sbt_pkg::PendBang: return KNe;
      sbt_pkg::PendLt: return KLe;
      sbt_pkg::PendGt: return KGe;
      sbt_pkg::PendAmp: return KAnd;
      default: return KOr;
    endcase
  endfunction

  task automatic line_up();
    if (sh_line != 24'hFF_FFFF) sh_line++;
  endtask

  task automatic grow();
    if (sh_len != 16'hFFFF) sh_len++;
  endtask

  // A lone ampersand or bar produces nothing.
  task automatic flush_op();
    case (sh_pend)
      sbt_pkg::PendEq: push_token(KAssign, sbt_pkg::ErrNone, sh_start, 16'd1);
      sbt_pkg::PendBang: push_token(KNot, sbt_pkg::ErrNone, sh_start, 16'd1);
      sbt_pkg::PendLt: push_token(KLt, sbt_pkg::ErrNone, sh_start, 16'd1);
      sbt_pkg::PendGt: push_token(KGt, sbt_pkg::ErrNone, sh_start, 16'd1);
      sbt_pkg::PendSlash: push_token(KSlash, sbt_pkg::ErrNone, sh_start, 16'd1);
      default: ;
    endcase
  endtask

  task automatic close_word();
    logic [5:0] kind;
    logic hit;
    kind = sbt_pkg::KindIdent;
    for (int k = 0; k < 18; k++) begin
      if (kind == sbt_pkg::KindIdent && keywords[k].len() == sh_len) begin
        hit = 1'b1;
        for (int i = 0; i < keywords[k].len(); i++)
          if (sh_word[i] != keywords[k][i]) hit = 1'b0;
        if (hit) kind = 6'(sbt_pkg::KindKwBase + k);
      end
    end
    push_token(kind, sbt_pkg::ErrNone, sh_start, sh_len);
  endtask

  task automatic open_token(logic [7:0] c);
    if (lone_kind(c) != sbt_pkg::KindNone) begin
      push_token(lone_kind(c), sbt_pkg::ErrNone, sh_pos, 16'd1);
    end else if (c inside {"=", "!", "<", ">", "&", "|", "/"}) begin
      sh_mode = sbt_pkg::ModeOp;
      sh_start = sh_pos;
      case (c)
        "=": sh_pend = sbt_pkg::PendEq;
        "!": sh_pend = sbt_pkg::PendBang;
        "<": sh_pend = sbt_pkg::PendLt;
        ">": sh_pend = sbt_pkg::PendGt;
        "&": sh_pend = sbt_pkg::PendAmp;
        "|": sh_pend = sbt_pkg::PendBar;
        default: sh_pend = sbt_pkg::PendSlash;
      endcase
    end else if (c == " " || c == "\t" || c == 8'h0d) begin
    end else if (c == "\n") begin
      line_up();
    end else if (c == "\"") begin
      sh_mode = sbt_pkg::ModeString;
      sh_start = sh_pos;
      sh_len = '0;
    end else if (digit(c)) begin
      sh_mode = sbt_pkg::ModeNumber;
      sh_start = sh_pos;
      sh_len = 16'd1;
    end else if (letter(c)) begin
      sh_mode = sbt_pkg::ModeIdent;
      sh_start = sh_pos;
      sh_len = 16'd1;
      foreach (sh_word[i]) sh_word[i] = 8'h00;
      sh_word[0] = c;
    end else begin
      push_token(sbt_pkg::KindInvalid, sbt_pkg::ErrBadChar, sh_pos, 16'd1);
    end
  endtask

  // Advances the shadow scanner by one byte and queues the tokens it yields.
  task automatic scan_byte(logic [7:0] c, logic fin);
    int unsigned prior_count;
    prior_count = token_q.size();
    case (sh_mode)
      sbt_pkg::ModeOp: begin
        if (c == pend_follow(sh_pend)) begin
          if (sh_pend == sbt_pkg::PendSlash) begin
            sh_mode = sbt_pkg::ModeComment;
          end else begin
            push_token(pend_pair_kind(sh_pend), sbt_pkg::ErrNone, sh_start, 16'd2);
            sh_mode = sbt_pkg::ModeIdle;
          end
        end else begin
          flush_op();
          sh_mode = sbt_pkg::ModeIdle;
          open_token(c);
        end
      end
      sbt_pkg::ModeNumber: begin
        if (digit(c)) begin
          grow();
        end else begin
          push_token(sbt_pkg::KindNumber, sbt_pkg::ErrNone, sh_start, sh_len);
          sh_mode = sbt_pkg::ModeIdle;
          open_token(c);
        end
      end
      sbt_pkg::ModeIdent: begin
        if (letter(c) || digit(c)) begin
          if (sh_len < 8) sh_word[sh_len] = c;
          grow();
        end else begin
          close_word();
          sh_mode = sbt_pkg::ModeIdle;
          open_token(c);
        end
      end
      sbt_pkg::ModeString: begin
        if (c == "\"") begin
          push_token(sbt_pkg::KindString, sbt_pkg::ErrNone, sh_start + 32'd1, sh_len);
          sh_mode = sbt_pkg::ModeIdle;
        end else begin
          if (c == "\n") line_up();
          grow();
        end
      end
      sbt_pkg::ModeComment: begin
        if (c == "\n") begin
          sh_mode = sbt_pkg::ModeIdle;
          open_token(c);
        end
      end
      default: begin
        sh_mode = sbt_pkg::ModeIdle;
        open_token(c);
      end
    endcase
    sh_pos++;
    if (fin) begin
      case (sh_mode)
        sbt_pkg::ModeOp: flush_op();
        sbt_pkg::ModeNumber: push_token(sbt_pkg::KindNumber, sbt_pkg::ErrNone, sh_start,
                                        sh_len);
        sbt_pkg::ModeIdent: close_word();
        sbt_pkg::ModeString: push_token(sbt_pkg::KindInvalid, sbt_pkg::ErrUnterm, sh_start,
                                        sh_len == 16'hFFFF ? sh_len : sh_len + 16'd1);
        default: ;
      endcase
      push_token(sbt_pkg::KindEnd, sbt_pkg::ErrNone, sh_pos, 16'd0);
      scanner_clear();
    end
    if (token_q.size() > prior_count) token_q[$].last = 1'b1;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(stim_row_t row);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= row.c;
    s_axis_tuser <= row.fin;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_byte(row.c, row.fin);
    if (row.typed) begin
      token_q[$].kind = row.kind;
      token_q[$].err = row.err;
    end
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Appends one lexical fragment, mostly well formed, sometimes noise.
  task automatic add_fragment();
    string ops[20] = '{"+", "-", "*", "/", "%", "=", "==", "!", "!=", "<", "<=", ">",
                       ">=", "&&", "||", "&", "|", ";", "(", "]"};
    string punct = ",.){}[";
    int unsigned n;
    case ($urandom_range(0, 11))
      0, 1: add_text(keywords[$urandom_range(0, 17)]);
      2: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
        text_q.push_back(8'("a" + $urandom_range(0, 25)));
        for (int i = 1; i < n; i++)
          case ($urandom_range(0, 3))
            0: text_q.push_back(8'("0" + $urandom_range(0, 9)));
            1: text_q.push_back(8'("A" + $urandom_range(0, 25)));
            2: text_q.push_back("_");
            default: text_q.push_back(8'("a" + $urandom_range(0, 25)));
          endcase
      end
      3: begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) text_q.push_back(8'("0" + $urandom_range(0, 9)));
      end
      4: begin
        text_q.push_back("\"");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          text_q.push_back(($urandom_range(0, 5) == 0) ? 8'h0a
                                                        : 8'(8'h20 + $urandom_range(0, 1)));
        if ($urandom_range(0, 5) != 0) text_q.push_back("\"");
      end
      5: add_text(ops[$urandom_range(0, 19)]);
      6: text_q.push_back(punct[$urandom_range(0, 5)]);
      7: begin
        if ($urandom_range(0, 1) != 0) add_text(" ");
        else add_text("\t\r ");
      end
      8: text_q.push_back("\n");
      9: add_text("// x=1;\n");
      10: text_q.push_back(8'($urandom_range(0, 255)));
      default: text_q.push_back(" ");
    endcase
  endtask

  // Receiver stall pattern: alternating stretches, now and then a long open one.
  initial begin
    int unsigned hold;
    m_axis_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        if ($urandom_range(0, 5) == 0) begin
          m_axis_tready <= 1'b1;
          hold = 30;
        end else begin
          m_axis_tready <= ~m_axis_tready;
          hold = $urandom_range(1, 6);
        end
      end else begin
        hold--;
      end
    end
  end

  // Output checker and watchdog.
  always @(posedge clk_i) begin
    token_rec_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        if (token_q.size() == 0) begin
          report("extra token", 32'd1, 32'd0);
        end else begin
          want = token_q.pop_front();
          if (m_axis_tdata[5:0] !== want.kind) report("kind", m_axis_tdata[5:0], want.kind);
          if (m_axis_tdata[7:6] !== want.err) report("error", m_axis_tdata[7:6], want.err);
          if (m_axis_tdata[39:8] !== want.start)
            report("offset", m_axis_tdata[39:8], want.start);
          if (m_axis_tdata[55:40] !== want.len)
            report("length", m_axis_tdata[55:40], want.len);
          if (m_axis_tdata[79:56] !== want.line)
            report("line", m_axis_tdata[79:56], want.line);
          if (m_axis_tuser !== want.last) report("run_end", m_axis_tuser, want.last);
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("source_byte_tokenizer_tb failed");
        $finish;
      end
    end
  end

  stim_row_t directed[24] = '{
    '{8'hFF, 1'b0, 1'b1, sbt_pkg::KindInvalid, sbt_pkg::ErrBadChar},
    '{8'h00, 1'b0, 1'b1, sbt_pkg::KindInvalid, sbt_pkg::ErrBadChar},
    '{"=", 1'b0, 1'b0, 6'd0, 2'd0}, '{"=", 1'b0, 1'b1, KEq, sbt_pkg::ErrNone},
    '{"&", 1'b0, 1'b0, 6'd0, 2'd0}, '{"a", 1'b0, 1'b0, 6'd0, 2'd0},
    '{"|", 1'b0, 1'b0, 6'd0, 2'd0}, '{"|", 1'b0, 1'b1, KOr, sbt_pkg::ErrNone},
    '{"/", 1'b0, 1'b0, 6'd0, 2'd0}, '{"/", 1'b0, 1'b0, 6'd0, 2'd0},
    '{"x", 1'b0, 1'b0, 6'd0, 2'd0}, '{"\n", 1'b0, 1'b0, 6'd0, 2'd0},
    '{"\"", 1'b0, 1'b0, 6'd0, 2'd0}, '{"q", 1'b0, 1'b0, 6'd0, 2'd0},
    '{"\"", 1'b0, 1'b1, sbt_pkg::KindString, sbt_pkg::ErrNone},
    '{"9", 1'b0, 1'b0, 6'd0, 2'd0},
    '{"<", 1'b0, 1'b0, 6'd0, 2'd0}, '{">", 1'b0, 1'b0, 6'd0, 2'd0},
    '{"!", 1'b0, 1'b0, 6'd0, 2'd0},
    '{"\"", 1'b1, 1'b1, sbt_pkg::KindEnd, sbt_pkg::ErrNone},
    '{"+", 1'b0, 1'b1, KPlus, sbt_pkg::ErrNone}, '{"i", 1'b0, 1'b0, 6'd0, 2'd0},
    '{"f", 1'b0, 1'b0, 6'd0, 2'd0},
    '{8'h80, 1'b1, 1'b1, sbt_pkg::KindEnd, sbt_pkg::ErrNone}
  };

  initial begin
    int unsigned sent;
    stim_row_t row;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tuser = 1'b0;
    scanner_clear();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_byte(directed[i]);
    sent = 24;

    while (sent < 410) begin
      text_q.delete();
      while (text_q.size() < $urandom_range(6, 40)) add_fragment();
      foreach (text_q[i]) begin
        row.c = text_q[i];
        row.fin = (i == text_q.size() - 1);
        row.typed = 1'b0;
        row.kind = sbt_pkg::KindNone;
        row.err = sbt_pkg::ErrNone;
        send_byte(row);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (token_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("source_byte_tokenizer_tb passed");
    end else begin
      $display("source_byte_tokenizer_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/sbt_pkg.sv
sv/sbt_scanner.sv
sv/source_byte_tokenizer.sv
tb/sv/source_byte_tokenizer_tb.sv
